[rtl/core/lcs_pkg.sv]
`default_nettype none
package lcs_pkg;

   // Width of one symbol of either string.
   localparam int SYM_W = 8;

   // One result item as it leaves the block.
   typedef struct packed {
      logic [SYM_W-1:0] out_symbol;
      logic             out_last;
      logic             empty_res;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/lcs_ram.sv]
`default_nettype none
// Simple dual-port synchronous RAM: one write port and one read port with
// registered read data. The read data holds until the next read.
module lcs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

[rtl/core/lcs_with_traceback_top.sv]
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_cmd, req_symbol, req_last
// rsp_      out        rsp_valid/rsp_stall  rsp_out_symbol, rsp_out_last, rsp_empty_res
//
// Items are taken while loading. The item that ends the second string starts a run:
// the score table is filled one cell at a time, with a symbol fetch and a row end per
// row; each traceback step reads the left and upper cells through the single read
// port of the score memory, and each result is read before it is offered. Reset is
// synchronous and active high; it clears only the counts, sequencer, fill and empty flags.
// The score memory needs no clearing: its border is never stored, and every interior
// cell is written before it is read in a run. The block stalls input during a run,
// and a stalled result simply holds its state until it is taken.
module lcs_with_traceback_top #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_cmd,
   input  wire logic [lcs_pkg::SYM_W-1:0] req_symbol,
   input  wire logic                    req_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [lcs_pkg::SYM_W-1:0]    rsp_out_symbol,
   output logic                         rsp_out_last,
   output logic                         rsp_empty_res
);

   // Widths that follow from the maximum string length.
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int LAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int TD  = MAX_LEN * MAX_LEN;
   localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

   // Sequencer states.
   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_ROW    = 4'd2;
   localparam logic [3:0] S_CELL   = 4'd3;
   localparam logic [3:0] S_ROWEND = 4'd4;
   localparam logic [3:0] S_LEN    = 4'd5;
   localparam logic [3:0] S_LENW   = 4'd6;
   localparam logic [3:0] S_TRD    = 4'd7;
   localparam logic [3:0] S_TRD2   = 4'd8;
   localparam logic [3:0] S_TEV    = 4'd9;
   localparam logic [3:0] S_ERD    = 4'd10;
   localparam logic [3:0] S_EOUT   = 4'd11;

   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  fc_ff, fc_in, sc_ff, sc_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [TAW-1:0] base_ff, base_in;
   logic           a_vld_ff, a_vld_in, a_top_ff, a_top_in;
   logic [CW-1:0]  a_j_ff, a_j_in;
   logic [CW-1:0]  left_ff, left_in, diag_ff, diag_in;
   logic [CW-1:0]  len_ff, len_in, pos_ff, pos_in, k_ff, k_in;
   logic           top_ff, top_in, empty_ff, empty_in;

   // Memory ports.
   logic                      f_we, f_re, s_we, s_re, t_we, t_re, n_we, n_re;
   logic [LAW-1:0]            f_waddr, f_raddr, s_waddr, s_raddr, n_waddr, n_raddr;
   logic [TAW-1:0]            t_waddr, t_raddr;
   logic [CW-1:0]             t_wdata, t_rdata;
   logic [lcs_pkg::SYM_W-1:0] f_rdata, s_rdata, n_rdata, n_wdata;

   logic                      accept;
   logic [CW-1:0]             up, left, diag, cell_val;
   logic [CW-1:0]             up_tb;
   logic                      match;
   lcs_pkg::rsp_type          rsp;

   lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_first (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(req_symbol),
      .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
   );

   lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_second (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(req_symbol),
      .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
   );

   // Score table holds only the interior cells; row and column zero read as zero.
   lcs_ram #(.WIDTH(CW), .DEPTH(TD)) u_score (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
   );

   lcs_ram #(.WIDTH(lcs_pkg::SYM_W), .DEPTH(MAX_LEN)) u_answer (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
   );

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;
   assign match     = (f_rdata == s_rdata);

   // Cell update of the fill pipeline, fed by the registered reads issued in stage one.
   always_comb begin
      up   = a_top_ff ? '0 : t_rdata;
      left = (a_j_ff == CW'(1)) ? '0 : left_ff;
      diag = (a_top_ff || (a_j_ff == CW'(1))) ? '0 : diag_ff;
      if (match) begin
         cell_val = CW'(diag + CW'(1));
      end else begin
         cell_val = (up > left) ? up : left;
      end
   end

   always_comb begin
      state_in = state_ff;
      fc_in    = fc_ff;
      sc_in    = sc_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      base_in  = base_ff;
      a_vld_in = 1'b0;
      a_j_in   = a_j_ff;
      a_top_in = a_top_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      top_in   = top_ff;
      empty_in = empty_ff;
      up_tb    = top_ff ? '0 : t_rdata;

      f_we    = 1'b0;
      f_waddr = fc_ff[LAW-1:0];
      f_re    = 1'b0;
      f_raddr = LAW'(i_ff - CW'(1));
      s_we    = 1'b0;
      s_waddr = sc_ff[LAW-1:0];
      s_re    = 1'b0;
      s_raddr = LAW'(j_ff - CW'(1));
      t_we    = 1'b0;
      t_waddr = TAW'(base_ff + TAW'(a_j_ff - CW'(1)));
      t_wdata = cell_val;
      t_re    = 1'b0;
      t_raddr = TAW'(base_ff - TAW'(MAX_LEN) + TAW'(j_ff - CW'(1)));
      n_we    = 1'b0;
      n_waddr = LAW'(pos_ff - CW'(1));
      n_wdata = f_rdata;
      n_re    = 1'b0;
      n_raddr = k_ff[LAW-1:0];

      // Stage two of the fill: write the cell whose operands arrived this cycle.
      if (a_vld_ff) begin
         t_we    = 1'b1;
         left_in = cell_val;
         diag_in = up;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (!req_cmd) begin
                  if (fc_ff < CW'(MAX_LEN)) begin
                     f_we  = 1'b1;
                     fc_in = CW'(fc_ff + CW'(1));
                  end
               end else begin
                  if (sc_ff < CW'(MAX_LEN)) begin
                     s_we  = 1'b1;
                     sc_in = CW'(sc_ff + CW'(1));
                  end
                  if (req_last) begin
                     state_in = S_START;
                  end
               end
            end
         end
         S_START: begin
            i_in    = CW'(1);
            base_in = '0;
            if ((fc_ff == '0) || (sc_ff == '0)) begin
               empty_in = 1'b1;
               state_in = S_EOUT;
            end else begin
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            f_re     = 1'b1;
            j_in     = CW'(1);
            state_in = S_CELL;
         end
         S_CELL: begin
            // Stage one of the fill: fetch the second symbol and the cell above.
            s_re     = 1'b1;
            t_re     = (i_ff != CW'(1));
            a_vld_in = 1'b1;
            a_j_in   = j_ff;
            a_top_in = (i_ff == CW'(1));
            j_in     = CW'(j_ff + CW'(1));
            if (j_ff == sc_ff) begin
               state_in = S_ROWEND;
            end
         end
         S_ROWEND: begin
            // The last cell of the row is written here, so the next row reads it safely.
            if (i_ff == fc_ff) begin
               state_in = S_LEN;
            end else begin
               i_in     = CW'(i_ff + CW'(1));
               base_in  = TAW'(base_ff + TAW'(MAX_LEN));
               state_in = S_ROW;
            end
         end
         S_LEN: begin
            t_re     = 1'b1;
            t_raddr  = TAW'(base_ff + TAW'(sc_ff - CW'(1)));
            j_in     = sc_ff;
            state_in = S_LENW;
         end
         S_LENW: begin
            len_in = t_rdata;
            pos_in = t_rdata;
            k_in   = '0;
            if (t_rdata == '0) begin
               empty_in = 1'b1;
               state_in = S_EOUT;
            end else begin
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            f_re     = 1'b1;
            s_re     = 1'b1;
            t_re     = (j_ff != CW'(1));
            t_raddr  = TAW'(base_ff + TAW'(j_ff - CW'(2)));
            top_in   = (j_ff == CW'(1));
            state_in = S_TRD2;
         end
         S_TRD2: begin
            left_in  = top_ff ? '0 : t_rdata;
            t_re     = (i_ff != CW'(1));
            top_in   = (i_ff == CW'(1));
            state_in = S_TEV;
         end
         S_TEV: begin
            if (match) begin
               n_we    = 1'b1;
               pos_in  = CW'(pos_ff - CW'(1));
               i_in    = CW'(i_ff - CW'(1));
               j_in    = CW'(j_ff - CW'(1));
               base_in = TAW'(base_ff - TAW'(MAX_LEN));
            end else if (left_ff > up_tb) begin
               j_in = CW'(j_ff - CW'(1));
            end else begin
               i_in    = CW'(i_ff - CW'(1));
               base_in = TAW'(base_ff - TAW'(MAX_LEN));
            end
            if ((i_in == '0) || (j_in == '0) || (pos_in == '0)) begin
               state_in = S_ERD;
            end else begin
               state_in = S_TRD;
            end
         end
         S_ERD: begin
            n_re     = 1'b1;
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (!rsp_stall) begin
               if (rsp.out_last) begin
                  fc_in    = '0;
                  sc_in    = '0;
                  empty_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = CW'(k_ff + CW'(1));
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp.out_symbol = empty_ff ? '0 : n_rdata;
      rsp.out_last   = empty_ff || (k_ff == CW'(len_ff - CW'(1)));
      rsp.empty_res  = empty_ff;
   end

   assign rsp_valid      = (state_ff == S_EOUT);
   assign rsp_out_symbol = rsp.out_symbol;
   assign rsp_out_last   = rsp.out_last;
   assign rsp_empty_res  = rsp.empty_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fc_ff    <= '0;
         sc_ff    <= '0;
         a_vld_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         sc_ff    <= sc_in;
         a_vld_ff <= a_vld_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      base_ff  <= base_in;
      a_j_ff   <= a_j_in;
      a_top_ff <= a_top_in;
      left_ff  <= left_in;
      diag_ff  <= diag_in;
      len_ff   <= len_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      top_ff   <= top_in;
   end

endmodule
`default_nettype wire

[rtl/core/lcs_checker.sv]
`default_nettype none
module lcs_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [lcs_pkg::SYM_W-1:0] rsp_out_symbol,
   input wire logic                      rsp_out_last,
   input wire logic                      rsp_empty_res
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_symbol))
      else $error("stalled result changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_out_last && (rsp_out_symbol == '0))
      else $error("empty result malformed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   a_resume: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last && !rsp_stall |=> !req_stall && !rsp_valid)
      else $error("block did not return to loading after final result");

endmodule

bind lcs_with_traceback_top lcs_checker u_lcs_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_out_symbol(rsp_out_symbol),
   .rsp_out_last(rsp_out_last), .rsp_empty_res(rsp_empty_res)
);
`default_nettype wire
